// ===== hdl/circular_fifo_with_search_core_defines.svh =====
// Assertion macros for the circular FIFO with search.
// Clock clk and active-low reset rst_n must be visible where these are used.
`ifndef CIRCULAR_FIFO_WITH_SEARCH_CORE_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CFS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CFS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFS_ASSERT(label, cond, msg)
`define CFS_ASSERT_IMPL(label, ante, cons, msg)
`define CFS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/cfs_pkg.sv =====
// Shared types and constants for the circular FIFO with search.
// No dependencies.
package cfs_pkg;

  localparam int DEPTH_DEF      = 8;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int OCC_W          = 4;
  localparam int OUT_TDATA_W    = 40;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POPW,
    S_SCAN
  } state_t;

endpackage

// ===== hdl/cfs_ram.sv =====
// Single-port-write, single-port-read word store with registered read data.
// Depends on cfs_pkg for parameter defaults.
module cfs_ram
  import cfs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WORD_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/circular_fifo_with_search_core.sv =====
// Top level of the circular FIFO with key search: control, indices, output register.
// Depends on cfs_pkg, cfs_ram and circular_fifo_with_search_core_defines.svh.
//
//  channel | handshake             | tuser        | tdata (low bit up)
//  in      | in_tvalid/in_tready   | op [1:0]     | value [31:0]
//  out     | out_tvalid/out_tready | status [1:0] | out_word, found, occupancy, is_full,
//          |                       |              | is_empty, zero fill
//
// Push, query, pop on empty and search on empty finish in the execute state; pop goes on to
// a wait state for the reload of the cached front word. Search scans the n occupied slots
// from the head, one slot a cycle on the single read port, and stops at the first match.
// Reset is synchronous; it empties the queue, the store itself is not cleared.
// Input is taken only in idle; a stalled result holds in the output register while the
// next item is taken, and finishing work waits until that register is free.
`include "circular_fifo_with_search_core_defines.svh"

module circular_fifo_with_search_core
  import cfs_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [1:0]             in_tuser,    // op
  input  logic [VALUE_W-1:0]     in_tdata,    // value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [1:0]             out_tuser,   // status
  output logic [OUT_TDATA_W-1:0] out_tdata    // out_word, found, occupancy, is_full, is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic [WORD_WIDTH-1:0] val_r;
  logic [WORD_WIDTH-1:0] front_r;
  logic [AW-1:0]         head_r, tail_r, scan_idx_r;
  logic [CW-1:0]         count_r, left_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VALUE_W-1:0]    out_word_r;
  logic                  out_found_r;
  logic [OCC_W-1:0]      out_occ_r;
  logic                  out_full_r, out_empty_r;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  logic                  accept, out_free, full_w, empty_w, key_hit;
  logic                  finish, do_push, do_pop, scan_start, scan_step;
  status_t               fin_status;
  logic                  fin_found;
  logic [WORD_WIDTH-1:0] fin_word;
  logic [CW-1:0]         fin_count;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    next_slot = (i == AW'(DEPTH - 1)) ? '0 : AW'(i + 1'b1);
  endfunction

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign full_w   = count_r == CW'(DEPTH);
  assign empty_w  = count_r == '0;
  assign key_hit  = rd_data == val_r;

  cfs_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    in_tready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    wr_en      = 1'b0;
    finish     = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    fin_status = ST_OK;
    fin_found  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_PUSH: begin
            if (out_free) begin
              finish = 1'b1;
              if (full_w) begin
                fin_status = ST_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                do_push = 1'b1;
              end
            end
          end
          OP_POP: begin
            if (empty_w) begin
              if (out_free) begin
                finish     = 1'b1;
                fin_status = ST_UNDERFLOW;
              end
            end else begin
              rd_en   = 1'b1;
              rd_addr = next_slot(head_r);
              do_pop  = 1'b1;
            end
          end
          OP_SEARCH: begin
            if (empty_w) begin
              finish = out_free;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head_r;
              scan_start = 1'b1;
            end
          end
          default: begin
            finish = out_free;
          end
        endcase
      end
      S_POPW: begin
        finish = out_free;
      end
      S_SCAN: begin
        if (key_hit) begin
          finish    = out_free;
          fin_found = 1'b1;
        end else if (left_r == '0) begin
          finish = out_free;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = scan_idx_r;
          scan_step = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end else if (do_pop) begin
          state_nxt = S_POPW;
        end else if (scan_start) begin
          state_nxt = S_SCAN;
        end
      end
      S_POPW, S_SCAN: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    fin_count = do_push ? CW'(count_r + 1'b1) : count_r;
    if (state_r == S_POPW) begin
      fin_word = front_r;
    end else if (do_push && empty_w) begin
      fin_word = val_r;
    end else if (empty_w) begin
      fin_word = '0;
    end else begin
      fin_word = front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_push) begin
        tail_r  <= next_slot(tail_r);
        count_r <= CW'(count_r + 1'b1);
      end else if (do_pop) begin
        head_r  <= next_slot(head_r);
        count_r <= CW'(count_r - 1'b1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_tuser);
      val_r <= WORD_WIDTH'(in_tdata);
    end
    if (do_push && empty_w) begin
      front_r <= val_r;
    end else if (finish && state_r == S_POPW) begin
      front_r <= rd_data;
    end
    if (scan_start) begin
      scan_idx_r <= next_slot(head_r);
      left_r     <= CW'(count_r - 1'b1);
    end else if (scan_step) begin
      scan_idx_r <= next_slot(scan_idx_r);
      left_r     <= CW'(left_r - 1'b1);
    end
    if (finish) begin
      out_status_r <= fin_status;
      out_word_r   <= VALUE_W'(fin_word);
      out_found_r  <= fin_found;
      out_occ_r    <= OCC_W'(fin_count);
      out_full_r   <= fin_count == CW'(DEPTH);
      out_empty_r  <= fin_count == '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'({out_empty_r, out_full_r, out_occ_r, out_found_r,
                                    out_word_r});

  `CFS_ASSERT(a_count_range, count_r <= CW'(DEPTH), "entry count above depth")
  `CFS_ASSERT(a_index_match, (head_r == tail_r) == (empty_w || full_w), "index and count mismatch")
  `CFS_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC, "accepted item not executed")
  `CFS_ASSERT_IMPL(a_scan_search, state_r == S_SCAN, op_r == OP_SEARCH && !empty_w, "bad scan")

endmodule

// ===== bench/circular_fifo_with_search_core_checker.sv =====
`timescale 1ns / 1ps
// Passive checker for circular_fifo_with_search_core: tracks queue contents from input
// transfers, predicts each result and compares it field by field. Depends on cfs_pkg.
module circular_fifo_with_search_core_checker
  import cfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [1:0]             in_tuser,
  input  logic [VALUE_W-1:0]     in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [1:0]             out_tuser,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending
);

  localparam int SLOTS = DEPTH_DEF;

  typedef struct {
    status_t     status;
    logic [31:0] word;
    logic        found;
    logic [3:0]  occ;
    logic        full;
    logic        empty;
  } fifo_reply_t;

  logic [31:0] shadow_words [SLOTS];
  int unsigned shadow_head;
  int unsigned shadow_tail;
  int unsigned shadow_fill;
  fifo_reply_t due_replies [$];

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    fifo_reply_t want;
    int unsigned scan;
    logic [31:0] key;
    if (!rst_n) begin
      shadow_head = 0;
      shadow_tail = 0;
      shadow_fill = 0;
      due_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result status %0d tdata %0h", $time, out_tuser, out_tdata);
        end else begin
          want = due_replies.pop_front();
          compare_field("status", 32'(want.status), 32'(out_tuser));
          compare_field("out_word", want.word, out_tdata[31:0]);
          compare_field("found", 32'(want.found), 32'(out_tdata[32]));
          compare_field("occupancy", 32'(want.occ), 32'(out_tdata[36:33]));
          compare_field("is_full", 32'(want.full), 32'(out_tdata[37]));
          compare_field("is_empty", 32'(want.empty), 32'(out_tdata[38]));
          compare_field("zero fill", 32'd0, 32'(out_tdata[OUT_TDATA_W-1:39]));
        end
      end
      if (in_tvalid && in_tready) begin
        key = in_tdata[31:0];
        want.status = ST_OK;
        want.word = '0;
        want.found = 1'b0;
        case (op_t'(in_tuser))
          OP_PUSH: begin
            if (shadow_fill == SLOTS) begin
              want.status = ST_OVERFLOW;
            end else begin
              shadow_words[shadow_tail] = key;
              shadow_tail = (shadow_tail + 1) % SLOTS;
              shadow_fill++;
            end
            if (shadow_fill != 0) want.word = shadow_words[shadow_head];
          end
          OP_POP: begin
            if (shadow_fill == 0) begin
              want.status = ST_UNDERFLOW;
            end else begin
              want.word = shadow_words[shadow_head];
              shadow_head = (shadow_head + 1) % SLOTS;
              shadow_fill--;
            end
          end
          default: begin
            if (op_t'(in_tuser) == OP_SEARCH) begin
              for (scan = 0; scan < shadow_fill; scan++) begin
                if (shadow_words[(shadow_head + scan) % SLOTS] == key) want.found = 1'b1;
              end
            end
            if (shadow_fill != 0) want.word = shadow_words[shadow_head];
          end
        endcase
        want.occ = 4'(shadow_fill);
        want.full = (shadow_fill == SLOTS);
        want.empty = (shadow_fill == 0);
        due_replies.push_back(want);
      end
      pending = due_replies.size();
    end
  end

endmodule

// ===== bench/circular_fifo_with_search_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for circular_fifo_with_search_core: clock, reset, stimulus, receiver
// back-pressure and verdict. Depends on cfs_pkg and circular_fifo_with_search_core_checker.
module circular_fifo_with_search_core_tb;
  import cfs_pkg::*;

  localparam int ITEMS      = 1400;
  localparam int CALM_ITEMS = 200;
  localparam int LIMIT      = 300000;
  localparam int LONG_HOLD  = 80;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [1:0]             in_tuser;
  logic [VALUE_W-1:0]     in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [1:0]             out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     pending;
  int                     cycle_count;
  bit                     calm;
  bit                     long_hold;
  logic [31:0]            key_pool [16];

  circular_fifo_with_search_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  circular_fifo_with_search_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int stall_left;
    int hold_count;
    stall_left = 0;
    hold_count = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && hold_count < LONG_HOLD) begin
        out_tready <= 1'b0;
        hold_count++;
      end else begin
        if (long_hold) begin
          long_hold = 1'b0;
          hold_count = 0;
        end
        if (stall_left > 0) begin
          out_tready <= 1'b0;
          stall_left--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(0, 3);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input op_t op, input logic [31:0] value);
    in_tuser <= op;
    in_tdata <= value;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic idle_in(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    op_t op;
    int bias;
    int pick;
    int push_lim;
    int pop_lim;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_PUSH;
    in_tdata = '0;
    calm = 1'b0;
    long_hold = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_POP, $urandom);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_QUERY, $urandom);
    send_item(OP_PUSH, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 32'h0000_0000);
    for (int i = 0; i < 6; i++) send_item(OP_PUSH, key_pool[2 + i]);
    send_item(OP_PUSH, 32'h1234_5678);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, key_pool[7]);
    send_item(OP_SEARCH, 32'h1234_5678);
    send_item(OP_QUERY, $urandom);
    repeat (3) send_item(OP_POP, $urandom);
    for (int i = 0; i < 3; i++) send_item(OP_PUSH, key_pool[8 + i]);
    send_item(OP_SEARCH, key_pool[10]);
    drain();

    // Hold the receiver off while pushes keep coming, so the input stalls.
    long_hold = 1'b1;
    repeat (16) send_item(OP_PUSH, pick_value());
    drain();

    for (int i = 0; i < ITEMS; i++) begin
      if (i % 40 == 0) bias = $urandom_range(0, 2);
      if (i == ITEMS / 2) drain();
      if (i == ITEMS - CALM_ITEMS) calm = 1'b1;
      case (bias)
        0: begin
          push_lim = 60;
          pop_lim = 80;
        end
        1: begin
          push_lim = 20;
          pop_lim = 70;
        end
        default: begin
          push_lim = 40;
          pop_lim = 70;
        end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < push_lim) op = OP_PUSH;
      else if (pick < pop_lim) op = OP_POP;
      else if (pick < 95) op = OP_SEARCH;
      else op = OP_QUERY;
      if (!calm && $urandom_range(0, 7) == 0) idle_in($urandom_range(1, 4));
      send_item(op, pick_value());
    end

    drain();
    repeat (2 * DEPTH_DEF + 4) @(negedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
